/* hdl/pai_pkg.sv */
// ----------------------------------------------------------------------------
// pai_pkg: shared types and constants for the planar arm IK pipeline
// Fixed-point widths, CORDIC angle table, cell payload structs, register map.
// ----------------------------------------------------------------------------
package pai_pkg;

  // Number of CORDIC micro-rotation cells per angle unit
  localparam int CORDIC_STAGES = 16;
  // Fraction bits of the angle and operand fixed-point format
  localparam int FRAC          = 16;

  // Square root: 42-bit radicand, 21-bit root, one root bit per cell
  localparam int SQRT_BITS = 21;
  localparam int SQ_W      = 2 * SQRT_BITS;
  localparam int SQ_T_W    = SQ_W + 2;

  // CORDIC operand, datapath and angle widths
  localparam int OP_W  = 36;
  localparam int CD_W  = OP_W + FRAC;
  localparam int Z_W   = 26;
  localparam int IDX_W = 5;

  localparam logic signed [Z_W-1:0] Z_90  = 26'sd5898240;
  localparam logic signed [Z_W-1:0] Z_180 = 26'sd11796480;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
  localparam logic signed [Z_W-1:0] ATAN_DEG [32] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0
  };

  // Register map (word index)
  localparam logic [1:0] REG_FIRST_LINK  = 2'd0;
  localparam logic [1:0] REG_SECOND_LINK = 2'd1;
  localparam logic [1:0] REG_TOOL_OFFSET = 2'd2;

  // Payload handed from one square root cell to the next
  typedef struct packed {
    logic [SQ_W-1:0]      rem;
    logic [SQRT_BITS-1:0] root;
  } sq_t;

  // Payload handed from one CORDIC cell to the next
  typedef struct packed {
    logic signed [CD_W-1:0] x;
    logic signed [CD_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   hold;
  } cordic_t;

endpackage

/* hdl/pai_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// pai_sqrt_cell: one root bit of the pipelined integer square root
// Tries to set root bit idx against the running remainder, registers result.
// ----------------------------------------------------------------------------
module pai_sqrt_cell import pai_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] idx,
  input  sq_t              din,
  output sq_t              dout
);

  logic [SQ_T_W-1:0] trial;
  sq_t               nxt;

  // Test (root + 2^idx)^2 - root^2 against the remainder
  always_comb begin
    trial = ({(SQ_T_W - SQRT_BITS)'(0), din.root} << (idx + 5'd1))
          + (SQ_T_W'(1) << {idx, 1'b0});
    nxt = din;
    if (trial <= {2'b00, din.rem}) begin
      nxt.rem  = din.rem - trial[SQ_W-1:0];
      nxt.root = din.root | (SQRT_BITS'(1) << idx);
    end
  end

  // Advance to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* hdl/pai_cordic_cell.sv */
// ----------------------------------------------------------------------------
// pai_cordic_cell: one vectoring-mode CORDIC micro-rotation
// Rotates toward the x axis by atan(2^-idx) and accumulates the angle.
// ----------------------------------------------------------------------------
module pai_cordic_cell import pai_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] idx,
  input  cordic_t          din,
  output cordic_t          dout
);

  logic signed [CD_W-1:0] dx;
  logic signed [CD_W-1:0] dy;
  cordic_t                nxt;

  // Rotate unless the angle was settled by an axis case
  always_comb begin
    dx  = din.y >>> idx;
    dy  = din.x >>> idx;
    nxt = din;
    if (!din.hold) begin
      if (din.y >= 0) begin
        nxt.x = din.x + dx;
        nxt.y = din.y - dy;
        nxt.z = din.z + ATAN_DEG[idx];
      end else begin
        nxt.x = din.x - dx;
        nxt.y = din.y + dy;
        nxt.z = din.z - ATAN_DEG[idx];
      end
    end
  end

  // Advance to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* hdl/planar_arm_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// planar_arm_inverse_kinematics: two-link planar arm solver with level tool
// Streams target points in, joint goals and deltas out, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block accepts one item per clock while not stalled. Items pass 5 setup
// stages, a 21-cell square root row, 3 product stages, three parallel
// 16-cell CORDIC rows and 2 output stages. All stages advance together
// whenever the output register is empty or its item is taken, so a stall on
// the result side holds every stage in place. Link lengths and tool offset
// are APB registers at byte addresses 0, 4, 8, reset to 250 mm. The user must
// write them only while no item is in flight; the block does not enforce it.
module planar_arm_inverse_kinematics import pai_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // target_x[11:0], target_y[23:12], present_shoulder_angle[33:24],
  // present_elbow_angle[43:34], present_wrist_angle[53:44], zero[55:54]
  input  logic [55:0] s_tdata,
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // shoulder_goal[9:0], elbow_goal[17:10], wrist_goal[27:18],
  // shoulder_delta[38:28], elbow_delta[49:39], wrist_delta[60:50], zero[63:61]
  output logic [63:0] m_tdata,
  // out_of_reach[0]
  output logic [0:0]  m_tuser
);

  localparam int LAT = 5 + SQRT_BITS + 3 + CORDIC_STAGES + 2;

  typedef struct packed {
    logic              bad;
    logic signed [9:0] ps;
    logic signed [9:0] pe;
    logic signed [9:0] pw;
  } tail_t;

  typedef struct packed {
    tail_t              tl;
    logic signed [12:0] cx;
    logic signed [11:0] cy;
    logic signed [25:0] num;
    logic [20:0]        den;
  } side_t;

  // Configuration registers
  logic [9:0] first_link_length;
  logic [9:0] second_link_length;
  logic [9:0] tool_offset_length;

  logic           adv;
  logic [LAT-1:0] vld;

  // Setup stages
  logic signed [12:0] s1_cx;
  logic signed [11:0] s1_cy;
  logic signed [9:0]  s1_ps, s1_pe, s1_pw;
  logic [23:0]        s2_cxx, s2_cyy;
  logic [19:0]        s2_l1sq, s2_l2sq;
  logic [20:0]        s2_den;
  logic signed [12:0] s2_cx;
  logic signed [11:0] s2_cy;
  tail_t              s2_tl;
  logic signed [25:0] s3_num;
  logic [20:0]        s3_den;
  logic               s3_r2zero;
  logic signed [12:0] s3_cx;
  logic signed [11:0] s3_cy;
  tail_t              s3_tl;
  logic [47:0]        s4_numsq;
  logic [41:0]        s4_densq;
  side_t              s4_side;
  logic [SQ_W-1:0]    s5_diff;
  side_t              s5_side;

  // Square root row
  sq_t   sq_pipe [0:SQRT_BITS];
  side_t sq_side [0:SQRT_BITS];

  // Product stages
  logic [31:0]          s6_ys, s6_a;
  logic signed [35:0]   s6_b;
  logic [SQRT_BITS-1:0] s6_s;
  side_t                s6_side;
  logic signed [35:0]   s7_xi;
  logic [31:0]          s7_ys;
  logic [SQRT_BITS-1:0] s7_s;
  side_t                s7_side;

  // CORDIC rows
  cordic_t cd_dir [0:CORDIC_STAGES];
  cordic_t cd_el  [0:CORDIC_STAGES];
  cordic_t cd_in  [0:CORDIC_STAGES];
  tail_t   cd_tl  [0:CORDIC_STAGES];

  logic signed [10:0] s9_sh;
  logic signed [10:0] s9_el;
  tail_t              s9_tl;

  // Combinational helpers
  logic signed [25:0] cx_e, cy_e;
  logic [25:0]        cxx_f, cyy_f;
  logic [19:0]        l1_e, l2_e, l1sq_f, l2sq_f, l1l2_f;
  logic [24:0]        r2;
  logic signed [51:0] num_e, numsq_f;
  logic [41:0]        den_e, densq_f;
  logic [25:0]        anum;
  logic               bad;
  logic [31:0]        l1_32, l2_32, s_32, den_32;
  logic signed [35:0] l2_36, num_36;
  logic signed [26:0] zsum;
  logic signed [10:0] wr_full;

  function automatic cordic_t cordic_pre(input logic signed [OP_W-1:0] y,
                                         input logic signed [OP_W-1:0] x);
    cordic_t                c;
    logic signed [OP_W-1:0] nx;
    logic signed [OP_W-1:0] ny;
    c.hold = 1'b0;
    c.z    = '0;
    nx     = x;
    ny     = y;
    if (y == '0) begin
      c.hold = 1'b1;
      c.z    = (x >= 0) ? '0 : Z_180;
    end else if (x == '0) begin
      c.hold = 1'b1;
      c.z    = (y > 0) ? Z_90 : -Z_90;
    end else if (x < 0) begin
      if (y > 0) begin
        nx  = y;
        ny  = -x;
        c.z = Z_90;
      end else begin
        nx  = -y;
        ny  = x;
        c.z = -Z_90;
      end
    end
    c.x = CD_W'(nx) <<< FRAC;
    c.y = CD_W'(ny) <<< FRAC;
    return c;
  endfunction

  function automatic logic signed [10:0] trunc_deg(input logic signed [26:0] v);
    logic [26:0] mag;
    logic [10:0] deg;
    mag = (v < 0) ? 27'(-v) : 27'(v);
    deg = mag[26:16];
    return (v < 0) ? -signed'(deg) : signed'(deg);
  endfunction

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_link_length  <= 10'd250;
      second_link_length <= 10'd250;
      tool_offset_length <= 10'd250;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_FIRST_LINK:  first_link_length  <= pwdata[9:0];
        REG_SECOND_LINK: second_link_length <= pwdata[9:0];
        REG_TOOL_OFFSET: tool_offset_length <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FIRST_LINK:  prdata = {22'd0, first_link_length};
      REG_SECOND_LINK: prdata = {22'd0, second_link_length};
      REG_TOOL_OFFSET: prdata = {22'd0, tool_offset_length};
      default:         prdata = '0;
    endcase
  end

  // Advance the whole pipeline when the output register is free
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Squares, products and reach test
  always_comb begin
    cx_e    = 26'(s1_cx);
    cy_e    = 26'(s1_cy);
    cxx_f   = 26'(cx_e * cx_e);
    cyy_f   = 26'(cy_e * cy_e);
    l1_e    = {10'd0, first_link_length};
    l2_e    = {10'd0, second_link_length};
    l1sq_f  = l1_e * l1_e;
    l2sq_f  = l2_e * l2_e;
    l1l2_f  = l1_e * l2_e;
    r2      = {1'b0, s2_cxx} + {1'b0, s2_cyy};
    num_e   = 52'(s3_num);
    numsq_f = num_e * num_e;
    den_e   = {21'd0, s3_den};
    densq_f = den_e * den_e;
    anum    = (s3_num < 0) ? 26'(-s3_num) : 26'(s3_num);
    bad     = s3_r2zero || (s3_den == '0) || (anum > {5'd0, s3_den});
  end

  // Setup stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cx <= {s_tdata[11], s_tdata[11:0]} - {3'b000, tool_offset_length};
      s1_cy <= s_tdata[23:12];
      s1_ps <= s_tdata[33:24];
      s1_pe <= s_tdata[43:34];
      s1_pw <= s_tdata[53:44];

      s2_cxx  <= cxx_f[23:0];
      s2_cyy  <= cyy_f[23:0];
      s2_l1sq <= l1sq_f;
      s2_l2sq <= l2sq_f;
      s2_den  <= {l1l2_f, 1'b0};
      s2_cx   <= s1_cx;
      s2_cy   <= s1_cy;
      s2_tl   <= '{bad: 1'b0, ps: s1_ps, pe: s1_pe, pw: s1_pw};

      s3_num    <= signed'({1'b0, r2}) - signed'({6'd0, s2_l1sq})
                 - signed'({6'd0, s2_l2sq});
      s3_den    <= s2_den;
      s3_r2zero <= (r2 == '0);
      s3_cx     <= s2_cx;
      s3_cy     <= s2_cy;
      s3_tl     <= s2_tl;

      s4_numsq       <= numsq_f[47:0];
      s4_densq       <= densq_f;
      s4_side.tl     <= '{bad: bad, ps: s3_tl.ps, pe: s3_tl.pe, pw: s3_tl.pw};
      s4_side.cx     <= s3_cx;
      s4_side.cy     <= s3_cy;
      s4_side.num    <= s3_num;
      s4_side.den    <= s3_den;

      s5_diff <= s4_side.tl.bad ? '0 : s4_densq - s4_numsq[SQ_W-1:0];
      s5_side <= s4_side;
    end
  end

  // Square root row, sideband travels alongside
  assign sq_pipe[0] = '{rem: s5_diff, root: '0};
  assign sq_side[0] = s5_side;

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_sqrt
    pai_sqrt_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .idx  (IDX_W'(SQRT_BITS - 1 - i)),
      .din  (sq_pipe[i]),
      .dout (sq_pipe[i+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side[i+1] <= sq_side[i];
      end
    end
  end

  // Operands of the inner-triangle angle
  always_comb begin
    l1_32  = {22'd0, first_link_length};
    l2_32  = {22'd0, second_link_length};
    s_32   = {11'd0, sq_pipe[SQRT_BITS].root};
    den_32 = {11'd0, sq_side[SQRT_BITS].den};
    l2_36  = signed'({26'd0, second_link_length});
    num_36 = 36'(sq_side[SQRT_BITS].num);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ys   <= l2_32 * s_32;
      s6_a    <= l1_32 * den_32;
      s6_b    <= l2_36 * num_36;
      s6_s    <= sq_pipe[SQRT_BITS].root;
      s6_side <= sq_side[SQRT_BITS];

      s7_xi   <= signed'({4'd0, s6_a}) + s6_b;
      s7_ys   <= s6_ys;
      s7_s    <= s6_s;
      s7_side <= s6_side;

      cd_dir[0] <= cordic_pre(36'(s7_side.cy), 36'(s7_side.cx));
      cd_el[0]  <= cordic_pre(signed'({15'd0, s7_s}), 36'(s7_side.num));
      cd_in[0]  <= cordic_pre(signed'({4'd0, s7_ys}), s7_xi);
      cd_tl[0]  <= s7_side.tl;
    end
  end

  // Three CORDIC rows: target direction, elbow, inner triangle
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    pai_cordic_cell u_dir (
      .clk (clk), .en (adv), .idx (IDX_W'(i)),
      .din (cd_dir[i]), .dout (cd_dir[i+1])
    );
    pai_cordic_cell u_el (
      .clk (clk), .en (adv), .idx (IDX_W'(i)),
      .din (cd_el[i]), .dout (cd_el[i+1])
    );
    pai_cordic_cell u_in (
      .clk (clk), .en (adv), .idx (IDX_W'(i)),
      .din (cd_in[i]), .dout (cd_in[i+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        cd_tl[i+1] <= cd_tl[i];
      end
    end
  end

  // Truncate angles, form goals and deltas
  assign zsum    = 27'(cd_dir[CORDIC_STAGES].z) + 27'(cd_in[CORDIC_STAGES].z);
  assign wr_full = s9_sh - s9_el;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_sh <= trunc_deg(zsum);
      s9_el <= trunc_deg(27'(cd_el[CORDIC_STAGES].z));
      s9_tl <= cd_tl[CORDIC_STAGES];

      if (s9_tl.bad) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {3'd0,
                    11'(wr_full - 11'(s9_tl.pw)),
                    11'(s9_el - 11'(s9_tl.pe)),
                    11'(s9_sh - 11'(s9_tl.ps)),
                    wr_full[9:0],
                    s9_el[7:0],
                    s9_sh[9:0]};
        m_tuser <= 1'b0;
      end
    end
  end

  // A stalled result blocks intake
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("item accepted while result stalled");

  // Unsolvable targets give all-zero goals and deltas
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("out of reach result carries nonzero fields");

  // Elbow goal stays within half a turn
  a_elbow_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[17:10] <= 8'd180)
    else $error("elbow goal above 180 degrees");

  // Wrist goal keeps the gripper level
  a_wrist_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      m_tdata[27:18] == 10'(m_tdata[9:0] - {2'b00, m_tdata[17:10]}))
    else $error("wrist goal is not shoulder minus elbow");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: planar_arm_inverse_kinematics
// Streams gripper targets through the IK pipeline under several link and
// tool settings and checks every joint goal and delta against a local solver.
// ----------------------------------------------------------------------------
module testbench import pai_pkg::*;;

  typedef struct packed {
    logic signed [9:0]  pw;
    logic signed [9:0]  pe;
    logic signed [9:0]  ps;
    logic signed [11:0] ty;
    logic signed [11:0] tx;
  } target_t;

  typedef struct {
    logic [9:0]  sh;
    logic [7:0]  el;
    logic [9:0]  wr;
    logic [10:0] dsh;
    logic [10:0] del;
    logic [10:0] dwr;
    logic        unreach;
  } joint_goal_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;

  target_t     pending_targets[$];
  joint_goal_t expected_goals[$];
  longint      link1 = 250, link2 = 250, tool = 250;
  int          idle_mode = 0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          errors = 0;

  planar_arm_inverse_kinematics dut (.*);

  // Clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Integer square root, floor
  function automatic longint isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Vectoring CORDIC, degrees with 16 fraction bits
  function automatic longint atan2_deg(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (y == 0) return (x >= 0) ? 0 : longint'(Z_180);
    if (x == 0) return (y > 0) ? longint'(Z_90) : -longint'(Z_90);
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y; y = -t; z = Z_90;
      end else begin
        x = -y; y = t; z = -longint'(Z_90);
      end
    end
    x = x <<< FRAC;
    y = y <<< FRAC;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_DEG[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_DEG[i]);
      end
    end
    return z;
  endfunction

  // Solve the arm for one target
  function automatic joint_goal_t solve_arm(target_t t);
    joint_goal_t g;
    longint cx, cy, r2, num, den, anum, s, sh, el, wr;
    cx = longint'(t.tx) - tool;
    cy = longint'(t.ty);
    r2 = cx * cx + cy * cy;
    num = r2 - link1 * link1 - link2 * link2;
    den = 2 * link1 * link2;
    anum = (num < 0) ? -num : num;
    g = '{default: '0};
    if (r2 == 0 || den == 0 || anum > den) begin
      g.unreach = 1'b1;
      return g;
    end
    s = isqrt(longint'(den * den - num * num));
    sh = (atan2_deg(cy, cx) + atan2_deg(link2 * s, link1 * den + link2 * num)) / 65536;
    el = atan2_deg(s, num) / 65536;
    wr = sh - el;
    g.sh = sh[9:0];
    g.el = el[7:0];
    g.wr = wr[9:0];
    g.dsh = 11'(sh - longint'(t.ps));
    g.del = 11'(el - longint'(t.pe));
    g.dwr = 11'(wr - longint'(t.pw));
    return g;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  // Sender: record accepted item, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_goals.push_back(solve_arm(target_t'(s_tdata[53:0])));
      if (!s_tvalid || s_tready) begin
        if (pending_targets.size() > 0 &&
            !(idle_mode == 0 && $urandom_range(99) < 33) &&
            !(idle_mode == 1 && $urandom_range(99) < 88)) begin
          s_tdata <= {2'b00, pending_targets.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !((idle_mode == 0 && $urandom_range(99) < 88) ||
                    (idle_mode == 1 && $urandom_range(99) < 33));
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    joint_goal_t g;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_goals.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got %h/%h", $realtime, m_tdata, m_tuser);
      end else begin
        g = expected_goals.pop_front();
        check_field("shoulder_goal", g.sh, m_tdata[9:0]);
        check_field("elbow_goal", g.el, m_tdata[17:10]);
        check_field("wrist_goal", g.wr, m_tdata[27:18]);
        check_field("shoulder_delta", g.dsh, m_tdata[38:28]);
        check_field("elbow_delta", g.del, m_tdata[49:39]);
        check_field("wrist_delta", g.dwr, m_tdata[60:50]);
        check_field("out_of_reach", g.unreach, m_tuser[0]);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FIRST_LINK:  link1 = longint'(val[9:0]);
      REG_SECOND_LINK: link2 = longint'(val[9:0]);
      REG_TOOL_OFFSET: tool = longint'(val[9:0]);
      default: ;
    endcase
  endtask

  task automatic set_arm(int l1, int l2, int l3);
    reg_write(REG_FIRST_LINK, l1);
    reg_write(REG_SECOND_LINK, l2);
    reg_write(REG_TOOL_OFFSET, l3);
  endtask

  // Hold until all results are in, then let the pipeline drain
  task automatic drain();
    while (pending_targets.size() > 0 || expected_goals.size() > 0 || s_tvalid)
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_target(int x, int y);
    target_t t;
    t.tx = 12'(x);
    t.ty = 12'(y);
    t.ps = 10'($urandom);
    t.pe = 10'($urandom);
    t.pw = 10'($urandom);
    pending_targets.push_back(t);
  endtask

  // Random targets: mostly inside reach, some anywhere
  task automatic add_random(int n);
    int span, x, y;
    span = int'(link1 + link2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20) begin
        add_target($signed(12'($urandom)), $signed(12'($urandom)));
      end else begin
        x = int'($urandom_range(2 * span)) - span + int'(tool);
        y = int'($urandom_range(2 * span)) - span;
        if (x > 2047) x = 2047;
        if (x < -2048) x = -2048;
        if (y > 2047) y = 2047;
        if (y < -2048) y = -2048;
        add_target(x, y);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset lengths
    add_target(250, 0);       // origin after tool offset
    add_target(750, 0);       // edge of reach, elbow straight
    add_target(2047, 2047);
    add_target(-2048, -2048);
    add_target(-2048, 2047);
    add_target(2047, -2048);
    add_target(250, 400);
    add_target(250, -400);
    add_target(-100, 0);
    add_target(-100, 200);
    add_target(-100, -200);
    add_target(500, 100);
    drain();
    // Elbow folded back fully
    set_arm(300, 200, 250);
    add_target(350, 0);
    add_target(850, 0);
    add_target(250, 100);
    drain();
    // Zero link length
    set_arm(0, 250, 0);
    add_target(100, 100);
    add_target(0, 0);
    drain();

    // Random phases across settings and idling patterns
    idle_mode = 0;
    set_arm(250, 250, 250);
    add_random(100);
    drain();
    set_arm(1023, 1023, 1023);
    add_random(70);
    drain();
    idle_mode = 1;
    set_arm(1, 1, 0);
    add_random(60);
    drain();
    set_arm(1, 1023, 0);
    add_random(100);
    drain();
    idle_mode = 2;
    set_arm(600, 300, 100);
    hold_token = hold_token + 1;
    add_random(100);
    drain();
    set_arm(250, 250, 250);
    add_random(70);
    drain();

    if (errors == 0)
      $display("planar_arm_inverse_kinematics verification clean");
    else
      $display("planar_arm_inverse_kinematics verification failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("planar_arm_inverse_kinematics verification failed");
    $finish;
  end
endmodule

/* planar_arm_inverse_kinematics.f */
hdl/pai_pkg.sv
hdl/pai_sqrt_cell.sv
hdl/pai_cordic_cell.sv
hdl/planar_arm_inverse_kinematics.sv
tb/testbench.sv
